// ===== design/alpha_blend_rgb_to_yuv420_top_defines.svh =====
// Assertion macros for the alpha blend and RGB to YCbCr 4:2:0 block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef ALPHA_BLEND_RGB_TO_YUV420_TOP_DEFINES_SVH
`define ALPHA_BLEND_RGB_TO_YUV420_TOP_DEFINES_SVH

// Same-cycle implication.
`define AB2Y_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AB2Y_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ab2y_pkg.sv =====
// Shared types, coefficients and helper functions for the alpha blend
// and BT.601 color conversion pipeline. No dependencies.
`default_nettype none

package ab2y_pkg;

    // Input item, row in the top bits so it maps straight onto s_tdata.
    typedef struct packed {
        logic [11:0] row;
        logic [11:0] column;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
    } pix_t;

    typedef struct packed {
        logic [11:0] row;
        logic [11:0] column;
    } pos_t;

    localparam int unsigned PIX_W   = $bits(pix_t);
    localparam int unsigned PROD_W  = 24;
    localparam int unsigned SUM_W   = 27;
    localparam int unsigned Q_SHIFT = 16;

    // Q16 coefficients (magnitudes; signs applied in the adder stage)
    localparam logic [15:0] KY_R = 16'd16843;
    localparam logic [15:0] KY_G = 16'd33030;
    localparam logic [15:0] KY_B = 16'd6423;
    localparam logic [15:0] KU_R = 16'd9699;
    localparam logic [15:0] KU_G = 16'd19071;
    localparam logic [15:0] KU_B = 16'd28770;
    localparam logic [15:0] KV_R = 16'd28770;
    localparam logic [15:0] KV_G = 16'd24117;
    localparam logic [15:0] KV_B = 16'd4653;

    localparam logic signed [SUM_W-1:0] OFF_Y = SUM_W'(16 << Q_SHIFT);
    localparam logic signed [SUM_W-1:0] OFF_C = SUM_W'(128 << Q_SHIFT);

    // x / 255 for x <= 255*255, as ((x + 1) * 257) >> 16.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] y;
        logic [24:0] p;
        y = {1'b0, x} + 17'd1;
        p = {y, 8'b0} + {8'b0, y};
        return p[23:16];
    endfunction

    // Signed Q16 sum to an 8-bit sample: negative -> 0, saturate at 255.
    function automatic logic [7:0] clamp_q16(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-Q_SHIFT-2:0] v;
        logic [7:0]               res;
        v = s[SUM_W-2:Q_SHIFT];
        if (s[SUM_W-1])
            res = 8'd0;
        else if (v > (SUM_W-Q_SHIFT-1)'(255))
            res = 8'd255;
        else
            res = v[7:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/ab2y_skid.sv =====
// Input skid register: keeps s_tready registered and holds one item
// while the pipeline is stalled. Depends on ab2y_pkg.
`default_nettype none

module ab2y_skid
    import ab2y_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire pix_t in_pix,
    input  wire logic en,
    output logic      out_valid,
    output pix_t      out_pix
);

    logic full_reg;
    logic full_next;
    pix_t hold_reg;
    logic fire;

    assign in_ready  = !full_reg;
    assign fire      = in_valid && !full_reg;
    assign out_valid = full_reg || fire;
    assign out_pix   = full_reg ? hold_reg : in_pix;

    always_comb
    begin
        full_next = full_reg;
        if (en)
            full_next = 1'b0;
        else if (fire)
            full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && !en)
            hold_reg <= in_pix;
    end

endmodule

`default_nettype wire

// ===== design/ab2y_blend.sv =====
// Two-stage alpha blend of RGB over the background color:
// stage 1 |c - bg| * alpha, stage 2 divide by 255 and add/subtract. Uses ab2y_pkg.
`default_nettype none

module ab2y_blend
    import ab2y_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire pix_t        in_pix,
    input  wire logic [23:0] bg,
    output logic             out_valid,
    output logic [2:0][7:0]  out_rgb,   // [2] red, [1] green, [0] blue
    output pos_t             out_pos
);

    logic [2:0][7:0]  chan;
    logic [2:0][7:0]  bgc;
    logic [2:0][7:0]  mag;
    logic [2:0]       neg;

    logic             v1_reg;
    logic [2:0][15:0] x1_reg;
    logic [2:0]       neg1_reg;
    logic [2:0][7:0]  bg1_reg;
    pos_t             pos1_reg;

    logic             v2_reg;
    logic [2:0][7:0]  rgb2_reg;
    logic [2:0][7:0]  rgb2_next;
    pos_t             pos2_reg;

    assign chan = {in_pix.red, in_pix.green, in_pix.blue};
    assign bgc  = bg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = chan[i] < bgc[i];
            mag[i] = neg[i] ? (bgc[i] - chan[i]) : (chan[i] - bgc[i]);
        end
    end

    // quotient truncates toward zero, so work on the magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (neg1_reg[i])
                rgb2_next[i] = bg1_reg[i] - div255(x1_reg[i]);
            else
                rgb2_next[i] = bg1_reg[i] + div255(x1_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                x1_reg[i] <= mag[i] * in_pix.alpha;
            neg1_reg <= neg;
            bg1_reg  <= bgc;
            pos1_reg <= '{row: in_pix.row, column: in_pix.column};
            rgb2_reg <= rgb2_next;
            pos2_reg <= pos1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_rgb   = rgb2_reg;
    assign out_pos   = pos2_reg;

endmodule

`default_nettype wire

// ===== design/ab2y_csc.sv =====
// Three-stage BT.601 color conversion: products, signed sums, clamp and
// 4:2:0 chroma selection into the output register. Uses ab2y_pkg.
`default_nettype none

module ab2y_csc
    import ab2y_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [2:0][7:0] in_rgb,
    input  wire pos_t            in_pos,
    output logic                 out_valid,
    output logic [7:0]           out_luma,
    output logic [7:0]           out_cb,
    output logic [7:0]           out_cr,
    output logic                 out_cvalid,
    output logic [10:0]          out_ccol,
    output logic [10:0]          out_crow
);

    // product order: y_r y_g y_b u_r u_g u_b v_r v_g v_b
    logic                     v3_reg;
    logic [8:0][PROD_W-1:0]   p3_reg;
    pos_t                     pos3_reg;

    logic                     v4_reg;
    logic signed [SUM_W-1:0]  y4_reg;
    logic signed [SUM_W-1:0]  u4_reg;
    logic signed [SUM_W-1:0]  w4_reg;
    logic signed [SUM_W-1:0]  y4_next;
    logic signed [SUM_W-1:0]  u4_next;
    logic signed [SUM_W-1:0]  w4_next;
    pos_t                     pos4_reg;

    logic                     v5_reg;
    logic [7:0]               luma5_reg;
    logic [7:0]               cb5_reg;
    logic [7:0]               cr5_reg;
    logic                     cv5_reg;
    logic                     cv4;
    logic [10:0]              ccol5_reg;
    logic [10:0]              crow5_reg;

    function automatic logic signed [SUM_W-1:0] ext(input logic [PROD_W-1:0] p);
        return $signed({{(SUM_W-PROD_W){1'b0}}, p});
    endfunction

    always_comb
    begin
        y4_next = ext(p3_reg[0]) + ext(p3_reg[1]) + ext(p3_reg[2]) + OFF_Y;
        u4_next = OFF_C + ext(p3_reg[5]) - ext(p3_reg[3]) - ext(p3_reg[4]);
        w4_next = OFF_C + ext(p3_reg[6]) - ext(p3_reg[7]) - ext(p3_reg[8]);
    end

    assign cv4 = !pos4_reg.column[0] && !pos4_reg.row[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_reg[0] <= KY_R * in_rgb[2];
            p3_reg[1] <= KY_G * in_rgb[1];
            p3_reg[2] <= KY_B * in_rgb[0];
            p3_reg[3] <= KU_R * in_rgb[2];
            p3_reg[4] <= KU_G * in_rgb[1];
            p3_reg[5] <= KU_B * in_rgb[0];
            p3_reg[6] <= KV_R * in_rgb[2];
            p3_reg[7] <= KV_G * in_rgb[1];
            p3_reg[8] <= KV_B * in_rgb[0];
            pos3_reg  <= in_pos;

            y4_reg   <= y4_next;
            u4_reg   <= u4_next;
            w4_reg   <= w4_next;
            pos4_reg <= pos3_reg;

            luma5_reg <= clamp_q16(y4_reg);
            cb5_reg   <= cv4 ? clamp_q16(u4_reg) : 8'd0;
            cr5_reg   <= cv4 ? clamp_q16(w4_reg) : 8'd0;
            cv5_reg   <= cv4;
            ccol5_reg <= pos4_reg.column[11:1];
            crow5_reg <= pos4_reg.row[11:1];
        end
    end

    assign out_valid  = v5_reg;
    assign out_luma   = luma5_reg;
    assign out_cb     = cb5_reg;
    assign out_cr     = cr5_reg;
    assign out_cvalid = cv5_reg;
    assign out_ccol   = ccol5_reg;
    assign out_crow   = crow5_reg;

endmodule

`default_nettype wire

// ===== design/alpha_blend_rgb_to_yuv420_top.sv =====
// Alpha blend over a background color and BT.601 RGB to YCbCr 4:2:0 conversion.
// Instantiates ab2y_skid, ab2y_blend and ab2y_csc; uses ab2y_pkg and the defines header.
//
// One pixel per clock, sustained while the output is not stalled. An accepted
// item comes out of the fifth register stage; the depth is set by the two
// blend stages (multiply, divide by 255) and the three conversion stages
// (products, sums, clamp). The whole pipeline advances together whenever the
// output register is empty or being taken; a one-item skid register at the
// input keeps s_tready registered.
// background_color is written through cfg_valid/cfg_data (always ready) and
// must only change while no pixel is in flight. Cb/Cr are zero and
// chroma_valid is low unless both column and row are even.
`default_nettype none

`include "alpha_blend_rgb_to_yuv420_top_defines.svh"

module alpha_blend_rgb_to_yuv420_top
    import ab2y_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [23:0] cfg_data,     // background: blue 7:0, green 15:8, red 23:16

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,      // alpha, red, green, blue, column[11:0], row[11:0]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,      // luma, chroma_blue, chroma_red,
                                           // chroma_column[10:0], chroma_row[10:0], 2 pad
    output logic [0:0]       m_tuser       // chroma_valid
);

    logic [23:0]     bg_reg;
    logic            en;
    logic            sk_valid;
    pix_t            sk_pix;
    logic            bl_valid;
    logic [2:0][7:0] bl_rgb;
    pos_t            bl_pos;
    logic [7:0]      luma;
    logic [7:0]      cb;
    logic [7:0]      cr;
    logic            cvalid;
    logic [10:0]     ccol;
    logic [10:0]     crow;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bg_reg <= 24'd0;
        else if (cfg_valid)
            bg_reg <= cfg_data;
    end

    assign en = !m_tvalid || m_tready;

    ab2y_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (pix_t'(s_tdata[PIX_W-1:0])),
        .en        (en),
        .out_valid (sk_valid),
        .out_pix   (sk_pix)
    );

    ab2y_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sk_valid),
        .in_pix    (sk_pix),
        .bg        (bg_reg),
        .out_valid (bl_valid),
        .out_rgb   (bl_rgb),
        .out_pos   (bl_pos)
    );

    ab2y_csc u_csc (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (bl_valid),
        .in_rgb     (bl_rgb),
        .in_pos     (bl_pos),
        .out_valid  (m_tvalid),
        .out_luma   (luma),
        .out_cb     (cb),
        .out_cr     (cr),
        .out_cvalid (cvalid),
        .out_ccol   (ccol),
        .out_crow   (crow)
    );

    assign m_tdata = {2'b00, crow, ccol, cr, cb, luma};
    assign m_tuser = cvalid;

    `AB2Y_ASSERT_NOW(a_chroma_zero, m_tvalid && !m_tuser[0], m_tdata[23:8] == 16'd0, "chroma not zeroed on odd position")
    `AB2Y_ASSERT_NEXT(a_skid_capture, s_tvalid && s_tready && !en, !s_tready, "stalled item not held in skid register")
    `AB2Y_ASSERT_NEXT(a_skid_hold, !s_tready && !en, !s_tready, "skid register dropped item during stall")

endmodule

`default_nettype wire

// ===== sim/alpha_blend_rgb_to_yuv420_top_tb.sv =====
// Self-checking bench for alpha_blend_rgb_to_yuv420_top: blended ARGB pixels in,
// checked Y/Cb/Cr 4:2:0 items out, several background colors. Uses ab2y_pkg.
module alpha_blend_rgb_to_yuv420_top_tb;
    import ab2y_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    // Q16 BT.601 limited-range weights
    localparam int WY_R = 16843;
    localparam int WY_G = 33030;
    localparam int WY_B = 6423;
    localparam int WU_R = 9699;
    localparam int WU_G = 19071;
    localparam int WU_B = 28770;
    localparam int WV_R = 28770;
    localparam int WV_G = 24117;
    localparam int WV_B = 4653;
    localparam int Y_BIAS = 16 << 16;
    localparam int C_BIAS = 128 << 16;

    typedef struct {
        logic [7:0]  luma;
        logic [7:0]  cb;
        logic [7:0]  cr;
        logic        chroma_ok;
        logic [10:0] chroma_col;
        logic [10:0] chroma_row;
    } yuv_sample_t;

    class yuv_scoreboard;
        logic [23:0]  background;
        yuv_sample_t  pending_q[$];
        int           errors;

        function new();
            background = 24'd0;
            errors     = 0;
        endfunction

        // bg + (c - bg) * a / 255, division truncating toward zero
        function int mix_channel(int bg, int c, int a);
            return bg + ((c - bg) * a) / 255;
        endfunction

        function logic [7:0] q16_to_byte(int s);
            if (s < 0)
                return 8'd0;
            if ((s >>> 16) > 255)
                return 8'd255;
            return 8'(s >>> 16);
        endfunction

        function void note_pixel(pix_t p);
            int r;
            int g;
            int b;
            yuv_sample_t e;
            r = mix_channel(int'(background[23:16]), int'(p.red), int'(p.alpha));
            g = mix_channel(int'(background[15:8]), int'(p.green), int'(p.alpha));
            b = mix_channel(int'(background[7:0]), int'(p.blue), int'(p.alpha));
            e.chroma_ok  = !p.column[0] && !p.row[0];
            e.luma       = q16_to_byte(WY_R * r + WY_G * g + WY_B * b + Y_BIAS);
            e.cb         = 8'd0;
            e.cr         = 8'd0;
            if (e.chroma_ok)
            begin
                e.cb = q16_to_byte(-WU_R * r - WU_G * g + WU_B * b + C_BIAS);
                e.cr = q16_to_byte(WV_R * r - WV_G * g - WV_B * b + C_BIAS);
            end
            e.chroma_col = p.column[11:1];
            e.chroma_row = p.row[11:1];
            pending_q.push_back(e);
        endfunction

        function void check_result(logic [47:0] d, logic [0:0] u);
            yuv_sample_t e;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result item: tdata %h tuser %b", d, u);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (d[7:0] !== e.luma)
            begin
                $error("luma: expected %0d, actual %0d", e.luma, d[7:0]);
                errors++;
            end
            if (d[15:8] !== e.cb)
            begin
                $error("chroma_blue: expected %0d, actual %0d", e.cb, d[15:8]);
                errors++;
            end
            if (d[23:16] !== e.cr)
            begin
                $error("chroma_red: expected %0d, actual %0d", e.cr, d[23:16]);
                errors++;
            end
            if (u[0] !== e.chroma_ok)
            begin
                $error("chroma_valid: expected %0d, actual %0d", e.chroma_ok, u[0]);
                errors++;
            end
            if (d[34:24] !== e.chroma_col)
            begin
                $error("chroma_column: expected %0d, actual %0d", e.chroma_col, d[34:24]);
                errors++;
            end
            if (d[45:35] !== e.chroma_row)
            begin
                $error("chroma_row: expected %0d, actual %0d", e.chroma_row, d[45:35]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [23:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    yuv_scoreboard sb;
    bit            src_burst;
    bit            sink_burst;
    int            idle_cycles;

    alpha_blend_rgb_to_yuv420_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // burst mode gives long stretches with no idling on that side
    function automatic int draw_wait(ref bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic pix_t make_pixel(logic [7:0] a, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b, logic [11:0] col, logic [11:0] row);
        pix_t p;
        p.alpha  = a;
        p.red    = r;
        p.green  = g;
        p.blue   = b;
        p.column = col;
        p.row    = row;
        return p;
    endfunction

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [11:0] rand_position();
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1:       return 12'd4095;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic pix_t rand_pixel();
        logic [7:0] a;
        case ($urandom_range(0, 9))
            0:       a = 8'd0;
            1:       a = 8'd255;
            default: a = 8'($urandom_range(0, 255));
        endcase
        return make_pixel(a, rand_channel(), rand_channel(), rand_channel(),
                          rand_position(), rand_position());
    endfunction

    // Entered and left at a falling edge; s_tvalid stays high for back-to-back items.
    task automatic send_pixel(input pix_t p);
        int gap;
        gap = draw_wait(src_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 56'(p);
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_pixel(p);
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_background(input logic [23:0] color);
        cfg_valid <= 1'b1;
        cfg_data  <= color;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.background = color;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n);
        repeat (n) send_pixel(rand_pixel());
    endtask

    // sink side: random stalls, then ready held until an item is taken
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_wait(sink_burst);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [23:0] bg_list [8];
        sb          = new();
        idle_cycles = 0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 24'd0;
        s_tvalid    = 1'b0;
        s_tdata     = 56'd0;
        src_burst   = 1'b0;
        sink_burst  = 1'b0;
        bg_list = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                    24'($urandom), 24'($urandom), 24'($urandom)};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset background is black
        send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 8'd255, 12'd0, 12'd0));
        send_pixel(make_pixel(8'd128, 8'd255, 8'd0, 8'd255, 12'd1, 12'd1));
        drain_pipeline();

        // mid-gray-ish background so both blend directions are exercised
        write_background(24'h40A0C8);
        send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 12'd0, 12'd0));
        send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 8'd255, 12'd1, 12'd0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd1));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd0, 8'd0, 12'd4094, 12'd4094));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd255, 12'd4095, 12'd4095));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd255, 12'd4094, 12'd0));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 8'd0, 12'd2, 12'd2));
        send_pixel(make_pixel(8'd128, 8'd255, 8'd0, 8'd255, 12'd4094, 12'd4095));
        send_pixel(make_pixel(8'd1, 8'd0, 8'd255, 8'd0, 12'd0, 12'd4094));
        send_pixel(make_pixel(8'd254, 8'd1, 8'd254, 8'd17, 12'd2048, 12'd2048));
        // channel below background: negative difference truncates toward zero
        send_pixel(make_pixel(8'd100, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0));
        send_pixel(make_pixel(8'd100, 8'd255, 8'd255, 8'd255, 12'd0, 12'd0));
        send_pixel(make_pixel(8'd200, 8'd64, 8'd160, 8'd200, 12'd4095, 12'd0));
        send_pixel(make_pixel(8'd170, 8'd170, 8'd85, 8'd85, 12'd2730, 12'd1365));
        send_pixel(make_pixel(8'd85, 8'd85, 8'd170, 8'd170, 12'd1365, 12'd2730));
        drain_pipeline();

        foreach (bg_list[i])
        begin
            write_background(bg_list[i]);
            run_random(135);
            drain_pipeline();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
